// ----- rtl/bdc_pkg.sv -----
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared constants for the backlight duty controller: field widths,
// register indexes, reset values and stream layouts.
// ----------------------------------------------------------------------------
package bdc_pkg;

    localparam int DUTY_W     = 30;
    localparam int SCALE_W    = 16;
    localparam int LEVEL_W    = 16;
    localparam int BYTE_W     = 8;
    localparam int PROD_W     = BYTE_W + DUTY_W;
    localparam int PCT_W      = 7;
    localparam int DVS_W      = SCALE_W + PCT_W;
    localparam int SUM_W      = PROD_W + 1;

    localparam int LEVEL_COUNT_DEFAULT = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LTH        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_TABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_PRES   = 3'd5;

    localparam logic [DUTY_W-1:0]  PERIOD_RESET = 30'd1000000;
    localparam logic [DUTY_W-1:0]  LTH_RESET    = 30'd0;
    localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd100;

    localparam logic [PCT_W-1:0] DIM_DIVISOR = 7'd100;

    localparam logic MODE_TABLE  = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

endpackage

// ----- rtl/bdc_ram.sv -----
// ----------------------------------------------------------------------------
// bdc_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bdc_ram #(
    parameter int WIDTH = bdc_pkg::LEVEL_W,
    parameter int DEPTH = bdc_pkg::LEVEL_COUNT_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/bdc_divider.sv -----
// ----------------------------------------------------------------------------
// bdc_divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bdc_divider #(
    parameter int DVD_W = bdc_pkg::PROD_W,
    parameter int DVS_W = bdc_pkg::DVS_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   trial_sub;
    logic             fits;

    assign trial     = {rem_reg, quo_reg[DVD_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/backlight_duty_controller.sv -----
// ----------------------------------------------------------------------------
// backlight_duty_controller
// Turns brightness requests into PWM duty values and drives power state.
// ----------------------------------------------------------------------------
// After reset the block sweeps the level table to zero, one entry per cycle,
// and accepts no stream item until that is done; configuration writes are
// taken at any time but should be made only while the block is idle. Items
// are handled one at a time. The result of a table write, or of an update
// whose brightness ends up zero, passes through ST_DONE into the output
// register. An update with a positive brightness reads the level table once
// in ST_READ and then runs a bit-serial divider over a 38-bit dividend in
// ST_DIV before its result passes through ST_DONE into the output register.
// In both cases the next item is accepted at the earliest when the result
// is loaded into the output register, whether or not the result has been
// taken. The output register lets a new item enter while a result waits.
// ----------------------------------------------------------------------------
module backlight_duty_controller #(
    parameter int LEVEL_COUNT = bdc_pkg::LEVEL_COUNT_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdc_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index[7:0], entry_value[23:8], brightness[31:24],
    // power_unblank[32], fb_unblank[33], core_blank[34], zero[39:35]
    input  logic [bdc_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode[0]
    input  logic                            s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // duty_ns[29:0], pwm_running[30], enable_pin[31]
    output logic [bdc_pkg::M_TDATA_W-1:0]   m_tdata,
    // duty_written[0]
    output logic                            m_tuser
);

    localparam int ADDR_W = $clog2(LEVEL_COUNT);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(LEVEL_COUNT - 1);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
    localparam logic [ST_W-1:0] ST_READ  = 3'd2;
    localparam logic [ST_W-1:0] ST_DIV   = 3'd3;
    localparam logic [ST_W-1:0] ST_DONE  = 3'd4;

    // Configuration registers.
    logic [bdc_pkg::DUTY_W-1:0]  period_reg;
    logic [bdc_pkg::DUTY_W-1:0]  lth_reg;
    logic [bdc_pkg::SCALE_W-1:0] scale_reg;
    logic                        use_table_reg;
    logic                        active_low_reg;
    logic                        pin_present_reg;

    // Control state.
    logic [ST_W-1:0]   state_reg,   state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              powered_reg, powered_next;
    logic              pin_reg,     pin_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // Payload registers.
    logic [bdc_pkg::BYTE_W-1:0] bright_reg, bright_next;
    logic                       dim_reg,    dim_next;
    logic [bdc_pkg::DUTY_W-1:0] res_duty_reg, res_duty_next;
    logic                       res_written_reg, res_written_next;
    logic [bdc_pkg::DUTY_W-1:0] out_duty_reg;
    logic                       out_written_reg;
    logic                       out_running_reg;
    logic                       out_pin_reg;
    logic                       out_load;

    // Input fields.
    logic [bdc_pkg::BYTE_W-1:0]  in_entry_index;
    logic [bdc_pkg::LEVEL_W-1:0] in_entry_value;
    logic [bdc_pkg::BYTE_W-1:0]  in_brightness;
    logic                        in_power_unblank;
    logic                        in_fb_unblank;
    logic                        in_core_blank;
    logic                        in_accept;
    logic                        bright_pos;

    // Table access.
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [bdc_pkg::LEVEL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [bdc_pkg::LEVEL_W-1:0] ram_rdata;
    logic [31:0]                 wr_idx;
    logic [31:0]                 rd_idx;

    // Arithmetic.
    logic                         dim_now;
    logic [bdc_pkg::BYTE_W-1:0]   mul_a;
    logic [bdc_pkg::DUTY_W-1:0]   mul_b;
    logic [bdc_pkg::DUTY_W-1:0]   span;
    logic [bdc_pkg::SCALE_W-1:0]  scale_eff;
    logic [bdc_pkg::PROD_W-1:0]   div_dividend;
    logic [bdc_pkg::DVS_W-1:0]    div_divisor;
    logic                         div_start;
    logic                         div_done;
    logic [bdc_pkg::PROD_W-1:0]   div_quotient;
    logic [bdc_pkg::SUM_W-1:0]    duty_sum;
    logic [bdc_pkg::DUTY_W-1:0]   duty_sat;

    assign in_entry_index   = s_tdata[7:0];
    assign in_entry_value   = s_tdata[23:8];
    assign in_brightness    = s_tdata[31:24];
    assign in_power_unblank = s_tdata[32];
    assign in_fb_unblank    = s_tdata[33];
    assign in_core_blank    = s_tdata[34];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign bright_pos = in_power_unblank && in_fb_unblank && !in_core_blank
                        && (in_brightness != '0);

    // ------------------------------------------------------------------
    // Level table
    // ------------------------------------------------------------------
    assign wr_idx = 32'(in_entry_index);
    assign rd_idx = (32'(in_brightness) < LEVEL_COUNT) ? 32'(in_brightness)
                                                       : 32'(LEVEL_COUNT - 1);
    assign ram_raddr = rd_idx[ADDR_W-1:0];

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = in_accept && (s_tuser == bdc_pkg::MODE_TABLE)
                        && (wr_idx < LEVEL_COUNT);
            ram_waddr = wr_idx[ADDR_W-1:0];
            ram_wdata = in_entry_value;
        end
    end

    bdc_ram #(
        .WIDTH (bdc_pkg::LEVEL_W),
        .DEPTH (LEVEL_COUNT)
    ) u_level_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Divider operands, from the table word read in ST_READ or the brightness
    // ------------------------------------------------------------------
    assign dim_now   = use_table_reg && (ram_rdata[15:8] != '0);
    assign span      = (period_reg > lth_reg) ? (period_reg - lth_reg) : '0;
    assign scale_eff = (scale_reg == '0) ? bdc_pkg::SCALE_W'(1) : scale_reg;

    always_comb
    begin
        if (dim_now)
        begin
            mul_a       = ram_rdata[15:8];
            mul_b       = period_reg;
            div_divisor = bdc_pkg::DVS_W'(scale_eff)
                          * bdc_pkg::DVS_W'(bdc_pkg::DIM_DIVISOR);
        end
        else
        begin
            mul_a       = use_table_reg ? ram_rdata[7:0] : bright_reg;
            mul_b       = span;
            div_divisor = bdc_pkg::DVS_W'(scale_eff);
        end
    end

    assign div_dividend = bdc_pkg::PROD_W'(mul_a) * bdc_pkg::PROD_W'(mul_b);

    bdc_divider #(
        .DVD_W (bdc_pkg::PROD_W),
        .DVS_W (bdc_pkg::DVS_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign duty_sum = {1'b0, div_quotient}
                      + (dim_reg ? '0 : bdc_pkg::SUM_W'(lth_reg));
    assign duty_sat = (duty_sum > bdc_pkg::SUM_W'(period_reg))
                      ? period_reg : duty_sum[bdc_pkg::DUTY_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        powered_next     = powered_reg;
        pin_next         = pin_reg;
        bright_next      = bright_reg;
        dim_next         = dim_reg;
        res_duty_next    = res_duty_reg;
        res_written_next = res_written_reg;
        div_start        = 1'b0;
        m_tvalid_next    = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_duty_next    = '0;
                    res_written_next = 1'b0;
                    state_next       = ST_DONE;
                    if (s_tuser == bdc_pkg::MODE_UPDATE)
                    begin
                        if (bright_pos)
                        begin
                            bright_next = in_brightness;
                            state_next  = ST_READ;
                        end
                        else if (powered_reg)
                        begin
                            res_written_next = 1'b1;
                            powered_next     = 1'b0;
                            if (pin_present_reg)
                            begin
                                pin_next = active_low_reg;
                            end
                        end
                    end
                end
            end
            ST_READ:
            begin
                div_start  = 1'b1;
                dim_next   = dim_now;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_duty_next    = duty_sat;
                    res_written_next = 1'b1;
                    powered_next     = 1'b1;
                    if (!powered_reg && pin_present_reg)
                    begin
                        pin_next = !active_low_reg;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            powered_reg     <= 1'b0;
            pin_reg         <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            period_reg      <= bdc_pkg::PERIOD_RESET;
            lth_reg         <= bdc_pkg::LTH_RESET;
            scale_reg       <= bdc_pkg::SCALE_RESET;
            use_table_reg   <= 1'b1;
            active_low_reg  <= 1'b0;
            pin_present_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            powered_reg  <= powered_next;
            pin_reg      <= pin_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bdc_pkg::CFG_PERIOD:     period_reg      <= cfg_data;
                    bdc_pkg::CFG_LTH:        lth_reg         <= cfg_data;
                    bdc_pkg::CFG_SCALE:      scale_reg       <= cfg_data[15:0];
                    bdc_pkg::CFG_USE_TABLE:  use_table_reg   <= cfg_data[0];
                    bdc_pkg::CFG_ACTIVE_LOW: active_low_reg  <= cfg_data[0];
                    bdc_pkg::CFG_PIN_PRES:   pin_present_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bright_reg      <= bright_next;
        dim_reg         <= dim_next;
        res_duty_reg    <= res_duty_next;
        res_written_reg <= res_written_next;
        if (out_load)
        begin
            out_duty_reg    <= res_duty_reg;
            out_written_reg <= res_written_reg;
            out_running_reg <= powered_reg;
            out_pin_reg     <= pin_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_pin_reg, out_running_reg, out_duty_reg};
    assign m_tuser  = out_written_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !out_written_reg |-> out_duty_reg == '0)
        else $error("Duty is nonzero on a result that writes no duty.");

    a_duty_in_period: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> out_duty_reg <= period_reg)
        else $error("Duty exceeds the PWM period.");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("Divider finished outside the divide state.");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_tready)
        else $error("A second item was taken before the first one finished.");

endmodule
